// ===== rtl/bbhp_pkg.sv =====
// Shared types, constants and a helper function for the byte buffer hash pair unit.
package bbhp_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // FNV prime is 2^40 + 0x1b3
  localparam int unsigned FNV_SHIFT    = 40;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam logic [63:0] MIX_M        = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MIX_SEED     = 64'h1fffffffffffffff;
  localparam int unsigned MIX_SHIFT    = 47;
  localparam int unsigned HEAD_DEPTH   = 7;

  function automatic logic [63:0] avalanche_f(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> MIX_SHIFT);
    t = t * MIX_M;
    t = t ^ (t >> MIX_SHIFT);
    return t;
  endfunction

  // Mix result of a zero-length buffer
  localparam logic [63:0] MIX_EMPTY = avalanche_f(MIX_SEED);

  // Operand fed to the shared multiplier
  typedef enum logic [2:0] {
    SRC_TOTAL,
    SRC_BYTE,
    SRC_MIX,
    SRC_TAIL,
    SRC_AVA
  } mul_src_e;

  // Register update applied by the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEED,
    OP_BYTE,
    OP_MIX,
    OP_TAIL,
    OP_TAIL_SKIP,
    OP_AVA
  } dp_op_e;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_src_e mul_src;
    dp_op_e   op;
    logic     out_load;
    logic     out_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic in_first;
    logic in_empty;
    logic last;
    logic lmod_zero;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/bbhp_mul.sv =====
// Iterative 64 x 64 low-half multiplier by the mix constant, one 32 x 32 product a cycle.
module bbhp_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  import bbhp_pkg::*;

  logic [1:0]  cnt_q, cnt_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] op_x, op_y;

  always_comb begin
    op_x   = a_i[31:0];
    op_y   = MIX_M[31:0];
    acc_d  = acc_q;
    case (cnt_q)
      2'd0: begin
        op_x = a_i[31:0];
        op_y = MIX_M[31:0];
      end
      2'd1: begin
        op_x  = a_i[31:0];
        op_y  = MIX_M[63:32];
        acc_d = prod_q;
      end
      2'd2: begin
        op_x  = a_i[63:32];
        op_y  = MIX_M[31:0];
        acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
      end
      default: begin
        op_x = a_i[31:0];
        op_y = MIX_M[31:0];
      end
    endcase
    prod_d = {32'd0, op_x} * {32'd0, op_y};
  end

  assign done_o = go_i && (cnt_q == 2'd3);
  assign res_o  = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign cnt_d  = go_i ? cnt_q + 2'd1 : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ===== rtl/bbhp_dp.sv =====
// Datapath: running hashes, head bytes, shared multiplier and output register.
module bbhp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [71:0]          in_data_i,
  input  logic                 in_last_i,
  input  logic [1:0]           in_user_i,
  input  bbhp_pkg::dp_cmd_t    cmd_i,
  output bbhp_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [127:0]         out_data_o
);
  import bbhp_pkg::*;

  logic [7:0]  in_byte;
  logic [63:0] in_total;
  logic        in_first, in_empty;

  logic [63:0] fnv_q, fnv_d;
  logic [63:0] mix_q, mix_d;
  logic [2:0]  head_cnt_q, head_cnt_d;
  logic [2:0]  lmod_q, lmod_d;
  logic [7:0]  head_q [HEAD_DEPTH];
  logic [63:0] total_q;
  logic [63:0] bmix_q;
  logic        last_q;
  logic [63:0] acc_q;
  logic        out_valid_q;
  logic [63:0] out_fnv_q, out_mix_q;

  logic [63:0] fnv_base, fnv_x;
  logic [2:0]  cnt_base;
  logic [63:0] tail_w;
  logic [63:0] mul_a, mul_res;
  logic        mul_done;
  logic        out_free;

  assign in_byte  = in_data_i[7:0];
  assign in_total = in_data_i[71:8];
  assign in_first = in_user_i[0];
  assign in_empty = in_user_i[1];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    for (int k = 0; k < HEAD_DEPTH; k++) begin
      if ((3'(k) < lmod_q) && (3'(k) < head_cnt_q)) begin
        tail_w[8*k +: 8] = head_q[k];
      end else begin
        tail_w[8*k +: 8] = 8'd0;
      end
    end
    tail_w[63:56] = 8'd0;
  end

  always_comb begin
    case (cmd_i.mul_src)
      SRC_TOTAL: mul_a = total_q;
      SRC_BYTE:  mul_a = bmix_q ^ (bmix_q >> MIX_SHIFT);
      SRC_MIX:   mul_a = mix_q;
      SRC_TAIL:  mul_a = mix_q ^ tail_w;
      SRC_AVA:   mul_a = acc_q ^ (acc_q >> MIX_SHIFT);
      default:   mul_a = mix_q;
    endcase
  end

  bbhp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mul_a),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // Byte step of FNV and the control state of a new item
  always_comb begin
    fnv_base   = in_first ? FNV_BASIS : fnv_q;
    fnv_x      = fnv_base ^ {56'd0, in_byte};
    cnt_base   = in_first ? 3'd0 : head_cnt_q;
    fnv_d      = fnv_q;
    head_cnt_d = head_cnt_q;
    lmod_d     = lmod_q;
    if (cmd_i.load) begin
      if (in_empty) begin
        fnv_d      = FNV_BASIS;
        head_cnt_d = 3'd0;
        lmod_d     = 3'd0;
      end else begin
        fnv_d = (fnv_x << FNV_SHIFT) + (fnv_x * {55'd0, FNV_PRIME_LO});
        if (cnt_base < 3'(HEAD_DEPTH)) begin
          head_cnt_d = cnt_base + 3'd1;
        end else begin
          head_cnt_d = cnt_base;
        end
        if (in_first) begin
          lmod_d = in_total[2:0];
        end
      end
    end
  end

  always_comb begin
    mix_d = mix_q;
    if (cmd_i.load && in_empty) begin
      mix_d = 64'd0;
    end else begin
      case (cmd_i.op)
        OP_SEED: mix_d = MIX_SEED ^ mul_res;
        OP_BYTE: mix_d = mix_q ^ mul_res;
        OP_MIX:  mix_d = mul_res;
        default: mix_d = mix_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fnv_q       <= FNV_BASIS;
      mix_q       <= 64'd0;
      head_cnt_q  <= 3'd0;
      lmod_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      fnv_q      <= fnv_d;
      mix_q      <= mix_d;
      head_cnt_q <= head_cnt_d;
      lmod_q     <= lmod_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      total_q <= in_total;
      last_q  <= in_last_i;
      bmix_q  <= {56'd0, in_byte} * MIX_M;
      if (!in_empty && (cnt_base < 3'(HEAD_DEPTH))) begin
        head_q[cnt_base] <= in_byte;
      end
    end
    case (cmd_i.op)
      OP_TAIL:      acc_q <= mul_res;
      OP_TAIL_SKIP: acc_q <= mix_q;
      OP_AVA:       acc_q <= mul_res ^ (mul_res >> MIX_SHIFT);
      default:      acc_q <= acc_q;
    endcase
    if (cmd_i.out_load) begin
      if (cmd_i.out_empty) begin
        out_fnv_q <= FNV_BASIS;
        out_mix_q <= MIX_EMPTY;
      end else begin
        out_fnv_q <= fnv_q;
        out_mix_q <= acc_q;
      end
    end
  end

  assign status_o.in_first  = in_first;
  assign status_o.in_empty  = in_empty;
  assign status_o.last      = last_q;
  assign status_o.lmod_zero = (lmod_q == 3'd0);
  assign status_o.mul_done  = mul_done;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_mix_q, out_fnv_q};

endmodule

// ===== rtl/bbhp_ctrl.sv =====
// Controller state machine sequencing the multiplies of each byte and the final mix.
module bbhp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bbhp_pkg::dp_status_t status_i,
  output bbhp_pkg::dp_cmd_t    cmd_o
);
  import bbhp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_BYTE  = 3'd2;
  localparam logic [2:0] ST_MIX   = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_AVA   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;
  localparam logic [2:0] ST_EMPTY = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.mul_go      = 1'b0;
    cmd_o.mul_src     = SRC_MIX;
    cmd_o.op          = OP_NONE;
    cmd_o.out_load    = 1'b0;
    cmd_o.out_empty   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_empty) begin
            state_d = ST_EMPTY;
          end else if (status_i.in_first) begin
            state_d = ST_SEED;
          end else begin
            state_d = ST_BYTE;
          end
        end
      end
      ST_SEED: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_src = SRC_TOTAL;
        if (status_i.mul_done) begin
          cmd_o.op = OP_SEED;
          state_d  = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_src = SRC_BYTE;
        if (status_i.mul_done) begin
          cmd_o.op = OP_BYTE;
          state_d  = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_src = SRC_MIX;
        if (status_i.mul_done) begin
          cmd_o.op = OP_MIX;
          state_d  = status_i.last ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        // skip the tail multiply when the length is a multiple of eight
        if (status_i.lmod_zero) begin
          cmd_o.op = OP_TAIL_SKIP;
          state_d  = ST_AVA;
        end else begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_src = SRC_TAIL;
          if (status_i.mul_done) begin
            cmd_o.op = OP_TAIL;
            state_d  = ST_AVA;
          end
        end
      end
      ST_AVA: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_src = SRC_AVA;
        if (status_i.mul_done) begin
          cmd_o.op = OP_AVA;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/byte_buffer_hash_pair_unit.sv =====
// A byte is taken only while idle, after all multiplies of the byte before it; the first
// byte of a buffer adds a seed multiply, and each byte runs two 64-bit multiplies on the
// one shared 32 x 32 multiplier. The last byte adds a tail multiply when the length is
// not a multiple of eight, and the avalanche; an empty buffer skips every multiply.
// A finished result waits in the output register while the next buffer's bytes are taken.
// Reset (asynchronous, active low) returns FNV to its basis, the mix to zero, drops the output.
module byte_buffer_hash_pair_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [71:0]  s_axis_tdata_i,  // [7:0] data_byte, [71:8] total_length
  input  logic         s_axis_tlast_i,  // last_byte
  input  logic [1:0]   s_axis_tuser_i,  // [0] first_byte, [1] empty_buffer
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // [63:0] fnv_hash, [127:64] mix_hash
);
  import bbhp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bbhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbhp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
